@@ design/radix2_complex_fft_macros.svh @@
// Assertion helpers used by the FFT top-level RTL.
`ifndef RADIX2_COMPLEX_FFT_MACROS_SVH
`define RADIX2_COMPLEX_FFT_MACROS_SVH

// Same-cycle implication, clocked on aclk, ignored while in reset.
`define R2FFT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, ignored while in reset.
`define R2FFT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/r2fft_pkg.sv @@
`default_nettype none

package r2fft_pkg;

    localparam int LOG_MAX_DEF      = 6;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int WORK_WIDTH_DEF   = 24;

    // configuration port
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 3;
    localparam int LOG_SIZE_W = 3;
    localparam logic [LOG_SIZE_W-1:0] LOG_SIZE_RESET = 3'd6;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_LOG_SIZE = 1'b0,
        CFG_INVERSE  = 1'b1
    } cfg_reg_t;

    // result fields
    localparam int OUT_W     = 24;
    localparam int IDX_W     = 6;
    localparam int M_TDATA_W = ((2 * OUT_W + IDX_W + 7) / 8) * 8;

    // twiddles: exp(-2*pi*j*k/64), k in 0..31, Q1.15
    localparam int TW_W    = 16;
    localparam int TW_BITS = 5;

    typedef struct packed {
        logic signed [TW_W-1:0] re;
        logic signed [TW_W-1:0] im;
    } twiddle_t;

    typedef struct packed {
        logic mul_en;   // capture operands and form the four products
        logic tw_en;    // round and saturate the twiddled value
    } bfly_ctl_t;

    function automatic logic signed [TW_W-1:0] cos_rom(input logic [TW_BITS-1:0] i);
        logic signed [TW_W-1:0] v;
        case (i)
            5'd0:    v = 16'sd32767;
            5'd1:    v = 16'sd32610;
            5'd2:    v = 16'sd32138;
            5'd3:    v = 16'sd31357;
            5'd4:    v = 16'sd30274;
            5'd5:    v = 16'sd28899;
            5'd6:    v = 16'sd27246;
            5'd7:    v = 16'sd25330;
            5'd8:    v = 16'sd23170;
            5'd9:    v = 16'sd20788;
            5'd10:   v = 16'sd18205;
            5'd11:   v = 16'sd15447;
            5'd12:   v = 16'sd12540;
            5'd13:   v = 16'sd9512;
            5'd14:   v = 16'sd6393;
            5'd15:   v = 16'sd3212;
            default: v = 16'sd0;
        endcase
        return v;
    endfunction

    function automatic twiddle_t twiddle(input logic [TW_BITS-1:0] k, input logic inv);
        twiddle_t w;
        logic signed [TW_W-1:0] c;
        logic signed [TW_W-1:0] s;
        if (k <= 5'd16) begin
            c = cos_rom(k);
            s = cos_rom(5'(6'd16 - {1'b0, k}));
        end else begin
            c = -cos_rom(5'(6'd32 - {1'b0, k}));
            s = cos_rom(5'(k - 5'd16));
        end
        w.re = c;
        w.im = inv ? s : -s;
        return w;
    endfunction

endpackage

`default_nettype wire

@@ design/r2fft_bfly.sv @@
`default_nettype none

// Radix-2 butterfly datapath: products, rounded twiddle, saturated sum/diff.
module r2fft_bfly #(
    parameter int WORK_WIDTH = r2fft_pkg::WORK_WIDTH_DEF
) (
    input  wire                           aclk,
    input  wire r2fft_pkg::bfly_ctl_t     ctl,
    input  wire signed [WORK_WIDTH-1:0]   a_re,
    input  wire signed [WORK_WIDTH-1:0]   a_im,
    input  wire signed [WORK_WIDTH-1:0]   b_re,
    input  wire signed [WORK_WIDTH-1:0]   b_im,
    input  wire r2fft_pkg::twiddle_t      w,
    output logic signed [WORK_WIDTH-1:0]  sum_re,
    output logic signed [WORK_WIDTH-1:0]  sum_im,
    output logic signed [WORK_WIDTH-1:0]  dif_re,
    output logic signed [WORK_WIDTH-1:0]  dif_im
);

    localparam int PW = WORK_WIDTH + r2fft_pkg::TW_W;
    localparam int SW = PW + 1;

    logic signed [PW-1:0]         p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [WORK_WIDTH-1:0] a_re_reg, a_im_reg;
    logic signed [WORK_WIDTH-1:0] t_re_reg, t_im_reg;
    logic signed [WORK_WIDTH-1:0] t_re_next, t_im_next;
    logic signed [SW-1:0]         acc_re, acc_im;

    function automatic logic signed [WORK_WIDTH-1:0] sat_acc(input logic signed [SW-1:0] v);
        logic [SW-WORK_WIDTH:0] top;
        top = v[SW-1:WORK_WIDTH-1];
        if ((&top) || !(|top))
            return v[WORK_WIDTH-1:0];
        else if (v[SW-1])
            return {1'b1, {(WORK_WIDTH-1){1'b0}}};
        else
            return {1'b0, {(WORK_WIDTH-1){1'b1}}};
    endfunction

    function automatic logic signed [WORK_WIDTH-1:0] sat_add(input logic signed [WORK_WIDTH:0] v);
        if (v[WORK_WIDTH] == v[WORK_WIDTH-1])
            return v[WORK_WIDTH-1:0];
        else if (v[WORK_WIDTH])
            return {1'b1, {(WORK_WIDTH-1){1'b0}}};
        else
            return {1'b0, {(WORK_WIDTH-1){1'b1}}};
    endfunction

    always_ff @(posedge aclk) begin
        if (ctl.mul_en) begin
            p_rr_reg <= PW'($signed(w.re) * $signed(b_re));
            p_ii_reg <= PW'($signed(w.im) * $signed(b_im));
            p_ri_reg <= PW'($signed(w.re) * $signed(b_im));
            p_ir_reg <= PW'($signed(w.im) * $signed(b_re));
            a_re_reg <= a_re;
            a_im_reg <= a_im;
        end
        if (ctl.tw_en) begin
            t_re_reg <= t_re_next;
            t_im_reg <= t_im_next;
        end
    end

    // round half up, floor shift by 15
    always_comb begin
        acc_re = SW'(p_rr_reg) - SW'(p_ii_reg) + SW'(16384);
        acc_im = SW'(p_ri_reg) + SW'(p_ir_reg) + SW'(16384);
        t_re_next = sat_acc(acc_re >>> 15);
        t_im_next = sat_acc(acc_im >>> 15);
    end

    assign sum_re = sat_add((WORK_WIDTH+1)'(a_re_reg) + (WORK_WIDTH+1)'(t_re_reg));
    assign sum_im = sat_add((WORK_WIDTH+1)'(a_im_reg) + (WORK_WIDTH+1)'(t_im_reg));
    assign dif_re = sat_add((WORK_WIDTH+1)'(a_re_reg) - (WORK_WIDTH+1)'(t_re_reg));
    assign dif_im = sat_add((WORK_WIDTH+1)'(a_im_reg) - (WORK_WIDTH+1)'(t_im_reg));

endmodule

`default_nettype wire

@@ design/radix2_complex_fft.sv @@
// Radix-2 decimation-in-time FFT over N = 2^log_size complex Q1.15 samples
// (log_size 1..LOG_MAX; 0 acts as 1, larger values as LOG_MAX). Samples stream
// in one per transaction and are written straight to their bit-reversed slot
// of a dual-read, single-write working store. After the N-th sample the block
// runs log_size stages of N/2 butterflies, one butterfly at a time in five steps
// (read, multiply, round, write upper, write lower on the single write port),
// then streams the N bins out in natural order, one at a time in three steps
// (store read, output register, handshake that waits on m_tready), last bin
// flagged by m_tlast.
// No input is taken while a frame is transforming or unloading. Inverse mode
// conjugates the twiddles and floor-divides each bin by N. Writing log_size
// restarts loading of the current frame; configure only while idle.
`default_nettype none

`include "radix2_complex_fft_macros.svh"

module radix2_complex_fft #(
    parameter int LOG_MAX      = r2fft_pkg::LOG_MAX_DEF,
    parameter int SAMPLE_WIDTH = r2fft_pkg::SAMPLE_WIDTH_DEF,
    parameter int WORK_WIDTH   = r2fft_pkg::WORK_WIDTH_DEF
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    // input samples
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    input  wire [((2*SAMPLE_WIDTH+7)/8)*8-1:0]   s_tdata,   // sample_re, sample_im
    // transform bins
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    output logic [r2fft_pkg::M_TDATA_W-1:0]      m_tdata,   // bin_re, bin_im, bin_index
    output logic                                 m_tlast,   // last_bin
    // configuration writes
    input  wire                                  cfg_we,
    input  wire [r2fft_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  wire [r2fft_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int AW    = LOG_MAX;
    localparam int CW    = LOG_MAX + 1;
    localparam int LGW   = $clog2(LOG_MAX + 1);
    localparam int DEPTH = 1 << LOG_MAX;
    localparam int OW    = r2fft_pkg::OUT_W;
    localparam int LW    = (SAMPLE_WIDTH > WORK_WIDTH) ? SAMPLE_WIDTH : WORK_WIDTH;
    localparam int XW    = (WORK_WIDTH > OW) ? WORK_WIDTH : OW;

    // Sequencer: load, five butterfly phases, three unload phases.
    typedef enum logic [8:0] {
        S_LOAD  = 9'b000000001,
        S_RD    = 9'b000000010,
        S_MUL   = 9'b000000100,
        S_TW    = 9'b000001000,
        S_WA    = 9'b000010000,
        S_WB    = 9'b000100000,
        S_ORD   = 9'b001000000,
        S_OCAP  = 9'b010000000,
        S_OWAIT = 9'b100000000
    } state_t;

    state_t                               state_reg, state_next;
    logic [r2fft_pkg::LOG_SIZE_W-1:0]     log_size_reg;
    logic                                 inverse_reg;
    logic [CW-1:0]                        load_cnt_reg, load_cnt_next;
    logic [LGW-1:0]                       st_reg, st_next;
    logic [AW-1:0]                        bf_reg, bf_next;
    logic [AW-1:0]                        oidx_reg, oidx_next;

    logic                                 m_tvalid_reg, m_tvalid_next;
    logic signed [OW-1:0]                 m_re_reg, m_im_reg;
    logic [r2fft_pkg::IDX_W-1:0]          m_idx_reg;
    logic                                 m_last_reg;

    // working store
    logic [WORK_WIDTH-1:0]                mem_re [DEPTH];
    logic [WORK_WIDTH-1:0]                mem_im [DEPTH];
    logic signed [WORK_WIDTH-1:0]         rd_a_re, rd_a_im, rd_b_re, rd_b_im;
    logic [AW-1:0]                        rd_a_addr, rd_b_addr, wr_addr;
    logic                                 wr_en;
    logic [WORK_WIDTH-1:0]                wr_re, wr_im;

    logic [LGW-1:0]                       lg;
    logic [CW-1:0]                        n_val;
    logic [AW-1:0]                        n_last, bf_last;
    logic                                 in_acc, frame_done, log_write;
    logic [AW-1:0]                        half_bit, half_mask, bf_m, bf_q;
    logic [AW+r2fft_pkg::TW_BITS-1:0]     tw_wide;
    r2fft_pkg::twiddle_t                  tw;
    r2fft_pkg::bfly_ctl_t                 bctl;
    logic signed [WORK_WIDTH-1:0]         sum_re, sum_im, dif_re, dif_im;
    logic signed [WORK_WIDTH-1:0]         smp_re, smp_im;
    logic signed [XW-1:0]                 o_re_x, o_im_x;

    function automatic logic [AW-1:0] bit_rev(input logic [AW-1:0] v, input logic [LGW-1:0] bits);
        logic [AW-1:0] r;
        r = '0;
        for (int i = 0; i < AW; i++) begin
            if (i < int'(bits))
                r[int'(bits) - 1 - i] = v[i];
        end
        return r;
    endfunction

    function automatic logic signed [WORK_WIDTH-1:0] sat_in(input logic signed [LW-1:0] v);
        logic [LW-WORK_WIDTH:0] top;
        top = v[LW-1:WORK_WIDTH-1];
        if ((&top) || !(|top))
            return v[WORK_WIDTH-1:0];
        else if (v[LW-1])
            return {1'b1, {(WORK_WIDTH-1){1'b0}}};
        else
            return {1'b0, {(WORK_WIDTH-1){1'b1}}};
    endfunction

    function automatic logic signed [OW-1:0] sat_out(input logic signed [XW-1:0] v);
        logic [XW-OW:0] top;
        top = v[XW-1:OW-1];
        if ((&top) || !(|top))
            return v[OW-1:0];
        else if (v[XW-1])
            return {1'b1, {(OW-1){1'b0}}};
        else
            return {1'b0, {(OW-1){1'b1}}};
    endfunction

    // effective transform length, clamped into range
    always_comb begin
        if (log_size_reg == '0)
            lg = LGW'(1);
        else if (log_size_reg > LOG_MAX)
            lg = LGW'(LOG_MAX);
        else
            lg = LGW'(log_size_reg);
    end

    assign n_val   = CW'(1) << lg;
    assign n_last  = AW'(n_val - 1'b1);
    assign bf_last = AW'((n_val >> 1) - 1'b1);

    assign s_tready   = (state_reg == S_LOAD);
    assign in_acc     = s_tvalid && s_tready;
    assign frame_done = (CW'(load_cnt_reg + 1'b1) >= n_val);
    assign log_write  = cfg_we && (cfg_addr == r2fft_pkg::CFG_LOG_SIZE);

    // butterfly pair: m has a zero at bit st, q = m with that bit set
    always_comb begin
        half_bit  = AW'(1) << st_reg;
        half_mask = half_bit - 1'b1;
        bf_m      = ((bf_reg & ~half_mask) << 1) | (bf_reg & half_mask);
        bf_q      = bf_m | half_bit;
        tw_wide   = (AW+r2fft_pkg::TW_BITS)'(bf_reg & half_mask)
                    << (r2fft_pkg::TW_BITS - int'(st_reg));
        tw        = r2fft_pkg::twiddle(tw_wide[r2fft_pkg::TW_BITS-1:0], inverse_reg);
    end

    assign smp_re = sat_in(LW'($signed(s_tdata[SAMPLE_WIDTH-1:0])));
    assign smp_im = sat_in(LW'($signed(s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH])));

    // store port selection
    always_comb begin
        rd_a_addr = (state_reg == S_ORD) ? oidx_reg : bf_m;
        rd_b_addr = bf_q;
        wr_en     = in_acc || (state_reg == S_WA) || (state_reg == S_WB);
        wr_addr   = bit_rev(load_cnt_reg[AW-1:0], lg);
        wr_re     = smp_re;
        wr_im     = smp_im;
        if (state_reg == S_WA) begin
            wr_addr = bf_m;
            wr_re   = sum_re;
            wr_im   = sum_im;
        end else if (state_reg == S_WB) begin
            wr_addr = bf_q;
            wr_re   = dif_re;
            wr_im   = dif_im;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_re[wr_addr] <= wr_re;
            mem_im[wr_addr] <= wr_im;
        end
        rd_a_re <= mem_re[rd_a_addr];
        rd_a_im <= mem_im[rd_a_addr];
        rd_b_re <= mem_re[rd_b_addr];
        rd_b_im <= mem_im[rd_b_addr];
    end

    assign bctl.mul_en = (state_reg == S_MUL);
    assign bctl.tw_en  = (state_reg == S_TW);

    r2fft_bfly #(
        .WORK_WIDTH (WORK_WIDTH)
    ) u_bfly (
        .aclk   (aclk),
        .ctl    (bctl),
        .a_re   (rd_a_re),
        .a_im   (rd_a_im),
        .b_re   (rd_b_re),
        .b_im   (rd_b_im),
        .w      (tw),
        .sum_re (sum_re),
        .sum_im (sum_im),
        .dif_re (dif_re),
        .dif_im (dif_im)
    );

    // inverse: floor divide by N
    always_comb begin
        o_re_x = XW'(rd_a_re);
        o_im_x = XW'(rd_a_im);
        if (inverse_reg) begin
            o_re_x = o_re_x >>> lg;
            o_im_x = o_im_x >>> lg;
        end
    end

    always_comb begin
        state_next    = state_reg;
        load_cnt_next = load_cnt_reg;
        st_next       = st_reg;
        bf_next       = bf_reg;
        oidx_next     = oidx_reg;
        m_tvalid_next = m_tvalid_reg;
        unique case (state_reg)
            S_LOAD: begin
                if (in_acc) begin
                    if (frame_done) begin
                        load_cnt_next = '0;
                        st_next       = '0;
                        bf_next       = '0;
                        state_next    = S_RD;
                    end else begin
                        load_cnt_next = CW'(load_cnt_reg + 1'b1);
                    end
                end
            end
            S_RD:  state_next = S_MUL;
            S_MUL: state_next = S_TW;
            S_TW:  state_next = S_WA;
            S_WA:  state_next = S_WB;
            S_WB: begin
                if (bf_reg == bf_last) begin
                    bf_next = '0;
                    if (st_reg == LGW'(lg - 1'b1)) begin
                        oidx_next  = '0;
                        state_next = S_ORD;
                    end else begin
                        st_next    = LGW'(st_reg + 1'b1);
                        state_next = S_RD;
                    end
                end else begin
                    bf_next    = AW'(bf_reg + 1'b1);
                    state_next = S_RD;
                end
            end
            S_ORD: state_next = S_OCAP;
            S_OCAP: begin
                m_tvalid_next = 1'b1;
                state_next    = S_OWAIT;
            end
            S_OWAIT: begin
                if (m_tready) begin
                    m_tvalid_next = 1'b0;
                    if (oidx_reg == n_last) begin
                        state_next = S_LOAD;
                    end else begin
                        oidx_next  = AW'(oidx_reg + 1'b1);
                        state_next = S_ORD;
                    end
                end
            end
            default: state_next = S_LOAD;
        endcase
        // a new length drops any partly loaded frame
        if (log_write)
            load_cnt_next = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_LOAD;
            log_size_reg <= r2fft_pkg::LOG_SIZE_RESET;
            inverse_reg  <= 1'b0;
            load_cnt_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            if (log_write)
                log_size_reg <= cfg_data[r2fft_pkg::LOG_SIZE_W-1:0];
            if (cfg_we && (cfg_addr == r2fft_pkg::CFG_INVERSE))
                inverse_reg <= cfg_data[0];
        end
    end

    always_ff @(posedge aclk) begin
        st_reg   <= st_next;
        bf_reg   <= bf_next;
        oidx_reg <= oidx_next;
        if (state_reg == S_OCAP) begin
            m_re_reg   <= sat_out(o_re_x);
            m_im_reg   <= sat_out(o_im_x);
            m_idx_reg  <= r2fft_pkg::IDX_W'(oidx_reg);
            m_last_reg <= (oidx_reg == n_last);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = r2fft_pkg::M_TDATA_W'({m_idx_reg, m_im_reg, m_re_reg});

    `R2FFT_ASSERT_NOW(a_no_load_while_out, m_tvalid, !s_tready, "input open while bin pending")
    `R2FFT_ASSERT_NOW(a_last_at_end, m_tvalid && m_tlast, oidx_reg == n_last, "last flag off end")
    `R2FFT_ASSERT_NEXT(a_frame_starts, in_acc && frame_done, state_reg == S_RD, "frame did not start")
    `R2FFT_ASSERT_NOW(a_stage_in_range, state_reg == S_WB, st_reg < lg, "stage past length")

endmodule

`default_nettype wire
